[src/assert_macros.svh]
// assertion macros for the checker file ial_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is active
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

[src/ial_pkg.sv]
// shared types and codes for the indexed array list
// no dependencies
package ial_pkg;
	localparam int DEPTH_DEF = 8;
	localparam int IDX_W     = 7;  // holds indexes and counts up to 127
	localparam int WORD_W    = 32;

	localparam logic [2:0] MODE_INS_AFTER  = 3'd0;
	localparam logic [2:0] MODE_INS_BEFORE = 3'd1;
	localparam logic [2:0] MODE_REMOVE     = 3'd2;
	localparam logic [2:0] MODE_SEARCH     = 3'd3;
	localparam logic [2:0] MODE_READ       = 3'd4;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_PAST_END  = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	// broadcast to every cell in the row
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [IDX_W-1:0]  at;
		logic [IDX_W-1:0]  fill;
		logic [IDX_W-1:0]  pos;
		logic [WORD_W-1:0] word;
	} ial_ctl_t;
endpackage

[src/indexed_array_list.sv]
// Indexed array list: an ordered list of up to DEPTH 32-bit words kept in a
// row of cells. Each request inserts after or before an index, removes at an
// index, searches for a word, or reads the entry at an index.
// Input channel (in_valid/in_ready): mode, position, word. Output channel
// (out_valid/out_ready): status, found_at, read_word, count, empty_flag,
// full_flag, one result per request, in request order.
// Each result passes the middle stage and the output register to out_valid.
// Throughput: one request per cycle while the receiver keeps up; an insert
// or remove moves every cell in the same cycle, and a search registers one
// match bit per cell before the priority encoder picks the first.
// When the receiver stalls, the result holds in the output register and one
// more request is taken into the middle stage; after that in_ready drops.
// Reset clears the count and empties both stages; the entry words hold no
// reset value and are only read below the count.
// DEPTH may range from 2 to 15.
// depends on ial_pkg, ial_cell, ial_find
module indexed_array_list import ial_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        mode,
	input  logic [3:0]        position,
	input  logic [WORD_W-1:0] word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [3:0]        found_at,
	output logic [WORD_W-1:0] read_word,
	output logic [3:0]        count,
	output logic              empty_flag,
	output logic              full_flag
);
	localparam int FW = $clog2(DEPTH + 1);

	logic [FW-1:0]     fill_q, fill_nx;
	logic              acc, adv;
	ial_ctl_t          ctl;
	logic [2:0]        st_dec;
	logic              srch_dec, read_ok;
	logic [IDX_W-1:0]  p_x, f_x;
	logic              is_full, list_empty;

	logic [WORD_W-1:0] cell_data [DEPTH];
	logic [WORD_W-1:0] cell_rd   [DEPTH];
	logic [DEPTH-1:0]  cell_match;
	logic [WORD_W-1:0] rd_or;

	logic              valid_s1;
	logic [2:0]        status_s1;
	logic              srch_s1;
	logic [DEPTH-1:0]  match_s1;
	logic [WORD_W-1:0] rd_s1;
	logic [3:0]        cnt_s1;
	logic              empty_s1, full_s1;

	logic              hit;
	logic [3:0]        hit_at;

	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [3:0]        found_q;
	logic [WORD_W-1:0] rd_q;
	logic [3:0]        cnt_q;
	logic              empty_q, full_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign acc      = in_valid && in_ready;

	assign p_x        = IDX_W'(position);
	assign f_x        = IDX_W'(fill_q);
	assign is_full    = (fill_q == FW'(DEPTH));
	assign list_empty = (fill_q == '0);

	// request decode
	always_comb begin
		ctl      = '0;
		ctl.fill = f_x;
		ctl.pos  = p_x;
		ctl.word = word;
		st_dec   = ST_DONE;
		srch_dec = 1'b0;
		read_ok  = 1'b0;
		case (mode)
			MODE_INS_AFTER: begin
				if (is_full) begin
					st_dec = ST_FULL;
				end else begin
					ctl.ins = acc;
					ctl.at  = (p_x >= f_x) ? f_x : p_x + IDX_W'(1);
				end
			end
			MODE_INS_BEFORE: begin
				if (is_full) begin
					st_dec = ST_FULL;
				end else begin
					ctl.ins = acc;
					ctl.at  = (p_x >= f_x) ? f_x : p_x;
				end
			end
			MODE_REMOVE: begin
				if (list_empty) begin
					st_dec = ST_EMPTY;
				end else if (p_x >= f_x) begin
					st_dec = ST_PAST_END;
				end else begin
					ctl.rem = acc;
					ctl.at  = p_x;
				end
			end
			MODE_SEARCH: begin
				srch_dec = 1'b1;
			end
			MODE_READ: begin
				if (p_x < f_x) begin
					read_ok = 1'b1;
				end else begin
					st_dec = ST_PAST_END;
				end
			end
			default: begin
				st_dec = ST_DONE;
			end
		endcase
	end

	always_comb begin
		fill_nx = fill_q;
		if (ctl.ins) begin
			fill_nx = fill_q + FW'(1);
		end else if (ctl.rem) begin
			fill_nx = fill_q - FW'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] prev_w, next_w;
		if (i == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid
			assign prev_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_w = cell_data[i];
		end else begin : g_inner
			assign next_w = cell_data[i+1];
		end
		ial_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.prev_data (prev_w),
			.next_data (next_w),
			.data      (cell_data[i]),
			.match     (cell_match[i]),
			.rd_part   (cell_rd[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_nx;
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// stage 1: decoded status, per-cell match bits, read data
	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= st_dec;
			srch_s1   <= srch_dec;
			match_s1  <= srch_dec ? cell_match : '0;
			rd_s1     <= read_ok ? rd_or : '0;
			cnt_s1    <= 4'(fill_nx);
			empty_s1  <= (fill_nx == '0);
			full_s1   <= (fill_nx == FW'(DEPTH));
		end
	end

	ial_find #(.DEPTH(DEPTH)) u_find (
		.match    (match_s1),
		.hit      (hit),
		.found_at (hit_at)
	);

	// output register
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			status_q <= srch_s1 ? (hit ? ST_DONE : ST_NOT_FOUND) : status_s1;
			found_q  <= (srch_s1 && hit) ? hit_at : '0;
			rd_q     <= rd_s1;
			cnt_q    <= cnt_s1;
			empty_q  <= empty_s1;
			full_q   <= full_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign found_at   = found_q;
	assign read_word  = rd_q;
	assign count      = cnt_q;
	assign empty_flag = empty_q;
	assign full_flag  = full_q;
endmodule

[src/ial_cell.sv]
// one list entry: shifts from its neighbors to open or close a gap
// depends on ial_pkg
module ial_cell import ial_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  ial_ctl_t          ctl,
	input  logic [WORD_W-1:0] prev_data,
	input  logic [WORD_W-1:0] next_data,
	output logic [WORD_W-1:0] data,
	output logic              match,
	output logic [WORD_W-1:0] rd_part
);
	logic [WORD_W-1:0] data_q;
	logic [IDX_W-1:0]  me;

	assign me = IDX_W'(IDX);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (me == ctl.at) begin
				data_q <= ctl.word;
			end else if (me > ctl.at) begin
				data_q <= prev_data;
			end
		end else if (ctl.rem) begin
			if (me >= ctl.at) begin
				data_q <= next_data;
			end
		end
	end

	assign data    = data_q;
	assign match   = (data_q == ctl.word) && (me < ctl.fill);
	assign rd_part = (me == ctl.pos) ? data_q : '0;
endmodule

[src/ial_find.sv]
// first-match priority encoder over the registered cell match bits
// depends on ial_pkg
module ial_find import ial_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic [DEPTH-1:0] match,
	output logic             hit,
	output logic [3:0]       found_at
);
	always_comb begin
		hit      = 1'b0;
		found_at = '0;
		// scan from the top so the lowest match wins
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit      = 1'b1;
				found_at = 4'(i);
			end
		end
	end
endmodule

[src/ial_checker.sv]
// port-level checks for the indexed array list, bound to the top level
// depends on assert_macros.svh and ial_pkg
`include "assert_macros.svh"
module ial_checker import ial_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [2:0]        mode,
	input logic [3:0]        position,
	input logic [WORD_W-1:0] word,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        status,
	input logic [3:0]        found_at,
	input logic [WORD_W-1:0] read_word,
	input logic [3:0]        count,
	input logic              empty_flag,
	input logic              full_flag
);
	// a stalled result keeps its contents
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(read_word) && $stable(count))

	// an empty list reports a zero count and cannot be full
	`ASSERT_IMP(a_empty_cnt, clk, arst_n, out_valid && empty_flag, count == 4'd0 && !full_flag)

	// read data only comes with a successful read
	`ASSERT_IMP(a_rd_ok, clk, arst_n, out_valid && status != ST_DONE, read_word == '0)

	// a result whose list is empty has nothing to find or read
	`ASSERT_IMP(a_empty_data, clk, arst_n, out_valid && empty_flag, found_at == 4'd0 && read_word == '0)
endmodule

bind indexed_array_list ial_checker u_ial_checker (.*);

[bench/indexed_array_list_tb.sv]
// self-checking bench for indexed_array_list: directed corner requests, then random traffic
// with random idling on both channels; a scoreboard mirrors the list and checks every result
// depends on ial_pkg and indexed_array_list
`timescale 1ns / 1ps

module indexed_array_list_tb;
	import ial_pkg::*;

	localparam int LIST_DEPTH = 8;
	localparam int ITEMS_PER_PHASE = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_CYCLES = 4;
	localparam int REPORT_MAX = 10;
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  found_at;
		logic [31:0] read_word;
		logic [3:0]  count;
		logic        empty_flag;
		logic        full_flag;
	} list_result_t;

	// mirror of the list; results are worked out when a request transfer happens
	class list_scoreboard;
		bit [31:0] entries [LIST_DEPTH];
		int unsigned fill;
		list_result_t results_due[$];
		int mismatches;

		function void note_request(logic [2:0] op, logic [3:0] pos, logic [31:0] w);
			list_result_t r;
			int unsigned at;
			int unsigned k;
			logic hit;
			r = '0;
			r.status = ST_DONE;
			case (op)
				MODE_INS_AFTER, MODE_INS_BEFORE: begin
					if (fill >= LIST_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						if (int'(pos) >= fill)
							at = fill;
						else if (op == MODE_INS_AFTER)
							at = pos + 1;
						else
							at = pos;
						for (k = fill; k > at; k--)
							entries[k] = entries[k - 1];
						entries[at] = w;
						fill++;
					end
				end
				MODE_REMOVE: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else if (int'(pos) >= fill) begin
						r.status = ST_PAST_END;
					end else begin
						for (k = pos; k + 1 < fill; k++)
							entries[k] = entries[k + 1];
						fill--;
					end
				end
				MODE_SEARCH: begin
					r.status = ST_NOT_FOUND;
					hit = 1'b0;
					for (k = 0; k < fill; k++) begin
						if (!hit && entries[k] == w) begin
							hit = 1'b1;
							r.status = ST_DONE;
							r.found_at = 4'(k);
						end
					end
				end
				MODE_READ: begin
					if (int'(pos) < fill)
						r.read_word = entries[pos];
					else
						r.status = ST_PAST_END;
				end
				default: ;
			endcase
			r.count = 4'(fill);
			r.empty_flag = (fill == 0);
			r.full_flag = (fill >= LIST_DEPTH);
			results_due.push_back(r);
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: status %0d found_at %0d read_word %h count %0d",
						got.status, got.found_at, got.read_word, got.count);
				return;
			end
			want = results_due.pop_front();
			if (got.status !== want.status || got.found_at !== want.found_at ||
					got.read_word !== want.read_word || got.count !== want.count ||
					got.empty_flag !== want.empty_flag || got.full_flag !== want.full_flag) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display({"result mismatch: expected status %0d found_at %0d read_word %h ",
						"count %0d empty %b full %b, got status %0d found_at %0d read_word %h ",
						"count %0d empty %b full %b"},
						want.status, want.found_at, want.read_word, want.count,
						want.empty_flag, want.full_flag, got.status, got.found_at,
						got.read_word, got.count, got.empty_flag, got.full_flag);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] mode;
	logic [3:0] position;
	logic [31:0] word;
	logic out_valid;
	logic out_ready;
	logic [2:0] status;
	logic [3:0] found_at;
	logic [31:0] read_word;
	logic [3:0] count;
	logic empty_flag;
	logic full_flag;

	int send_idle_pct;
	int recv_idle_pct;
	int holds_asked;
	int stall_cycles;
	list_scoreboard lists;

	// a few recurring words so searches hit and duplicates show up
	logic [31:0] common_words [4] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0001,
		32'h7fff_fffe};

	indexed_array_list #(.DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.position(position),
		.word(word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found_at(found_at),
		.read_word(read_word),
		.count(count),
		.empty_flag(empty_flag),
		.full_flag(full_flag)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send_request(logic [2:0] op, logic [3:0] pos, logic [31:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		position <= pos;
		word <= w;
		do @(posedge clk); while (!in_ready);
		lists.note_request(op, pos, w);
	endtask

	function automatic logic [31:0] pick_word();
		if ($urandom_range(1))
			return common_words[$urandom_range(3)];
		return $urandom;
	endfunction

	// mostly positions inside or just past the list, sometimes anywhere
	task automatic send_random_request();
		int r;
		int ins_w;
		int rem_w;
		logic [2:0] op;
		logic [3:0] pos;
		logic [31:0] w;
		r = $urandom_range(99);
		ins_w = (lists.fill < LIST_DEPTH / 2) ? 40 : 25;
		rem_w = (lists.fill < LIST_DEPTH / 2) ? 20 : 35;
		if (r < ins_w)
			op = $urandom_range(1) ? MODE_INS_AFTER : MODE_INS_BEFORE;
		else if (r < ins_w + rem_w)
			op = MODE_REMOVE;
		else if (r < ins_w + rem_w + 20)
			op = MODE_SEARCH;
		else if (r < 96)
			op = MODE_READ;
		else
			op = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
		if ($urandom_range(99) < 80)
			pos = 4'($urandom_range(lists.fill));
		else
			pos = 4'($urandom_range(15));
		if (op == MODE_SEARCH && lists.fill > 0 && $urandom_range(99) < 70)
			w = lists.entries[$urandom_range(lists.fill - 1)];
		else
			w = pick_word();
		send_request(op, pos, w);
	endtask

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			lists.check_result('{status, found_at, read_word, count, empty_flag, full_flag});
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("indexed_array_list_tb NOT OK");
			$finish;
		end
	end

	initial begin
		lists = new();
		stall_cycles = 0;
		holds_asked = 0;
		send_idle_pct = 7;
		recv_idle_pct = 81;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_INS_AFTER;
		position <= 4'd0;
		word <= 32'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// empty list corners
		send_request(MODE_REMOVE, 4'd0, 32'h0);
		send_request(MODE_SEARCH, 4'd0, 32'h0);
		send_request(MODE_READ, 4'd15, 32'h0);
		send_request(MODE_UNUSED_LO, 4'd3, 32'hffff_ffff);
		// appends: index past the end and index equal to the count, then inserts up to a full list
		send_request(MODE_INS_AFTER, 4'd15, 32'hffff_ffff);
		send_request(MODE_INS_BEFORE, 4'd15, 32'h0000_0000);
		send_request(MODE_INS_BEFORE, 4'd2, 32'ha5a5_a5a5);
		send_request(MODE_INS_BEFORE, 4'd0, 32'h1234_5678);
		send_request(MODE_INS_AFTER, 4'd0, 32'h5a5a_5a5a);
		send_request(MODE_INS_AFTER, 4'd4, 32'h0000_0001);
		send_request(MODE_INS_BEFORE, 4'd3, 32'h8000_0000);
		send_request(MODE_INS_AFTER, 4'd2, 32'hffff_ffff);
		// full list
		send_request(MODE_INS_AFTER, 4'd0, 32'hdead_beef);
		send_request(MODE_INS_BEFORE, 4'd15, 32'hdead_beef);
		send_request(MODE_SEARCH, 4'd0, 32'hffff_ffff);
		send_request(MODE_SEARCH, 4'd0, 32'hdead_beef);
		send_request(MODE_READ, 4'd7, 32'h0);
		send_request(MODE_READ, 4'd8, 32'h0);
		send_request(MODE_UNUSED_HI, 4'd15, 32'h0);
		// removes: past end, last, first, middle
		send_request(MODE_REMOVE, 4'd15, 32'h0);
		send_request(MODE_REMOVE, 4'd7, 32'h0);
		send_request(MODE_REMOVE, 4'd0, 32'h0);
		send_request(MODE_REMOVE, 4'd3, 32'h0);
		send_request(MODE_UNUSED_MID, 4'd1, 32'h0);

		for (int i = 0; i < ITEMS_PER_PHASE; i++)
			send_random_request();
		send_idle_pct = 81;
		recv_idle_pct = 7;
		for (int i = 0; i < ITEMS_PER_PHASE; i++)
			send_random_request();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
			// receiver holds off while requests keep coming, so the input stalls
			if (i == ITEMS_PER_PHASE / 2)
				holds_asked++;
			send_random_request();
		end
		in_valid <= 1'b0;

		while (lists.results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (lists.mismatches == 0 && lists.results_due.size() == 0)
			$display("indexed_array_list_tb OK");
		else
			$display("indexed_array_list_tb NOT OK");
		$finish;
	end
endmodule

[filelist.f]
+incdir+src
src/ial_pkg.sv
src/ial_cell.sv
src/ial_find.sv
src/indexed_array_list.sv
src/ial_checker.sv
bench/indexed_array_list_tb.sv
